FILE: rtl/fcr_pkg.sv
package fcr_pkg;

  localparam int unsigned IDX_W       = 7;
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned LEAD_DEPTH  = 5;
  localparam int unsigned LEAD_IDX_W  = $clog2(LEAD_DEPTH);

  localparam logic [7:0] HEAD_BYTE = 8'h61;
  localparam logic [7:0] TAIL_BYTE = 8'h23;

  localparam logic [3:0][7:0] WORD_OPEN  = {8'h6E, 8'h65, 8'h70, 8'h6F};
  localparam logic [4:0][7:0] WORD_CLOSE = {8'h65, 8'h73, 8'h6F, 8'h6C, 8'h63};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_SUM  = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } fcr_status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } fcr_cmd_t;

  typedef struct packed {
    logic        frame_done;
    fcr_status_t frame_status;
    fcr_cmd_t    command_seen;
    logic        relay_request;
  } fcr_result_t;

endpackage

FILE: rtl/framed_command_receiver_top.sv
// Framed command receiver.
// The in_ channel carries one received serial byte per transaction. The parser
// hunts for the head byte, reads a length, the payload, an XOR checksum and
// the tail, and keeps a relay flag that a good "open" frame sets and a good
// "close" frame clears.
// Every accepted byte yields exactly one transaction on the out_ channel: the
// frame-done flag, the frame status, the command seen and the relay flag.
// The byte is captured in an input register, parsed, and the result is
// presented from an output register.
// Throughput is one byte per cycle while the receiver keeps out_ready high.
// When the receiver holds out_ready low the output register keeps its
// transaction, the input register fills, and in_ready then falls; bytes are
// never dropped. A new byte is accepted in the same cycle a finished result
// is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to hunting for a head byte and turns the relay flag off.
module framed_command_receiver_top
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_frame_done,
  output logic [1:0] out_frame_status,
  output logic [1:0] out_command_seen,
  output logic       out_relay_request
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  fcr_result_t out_result_r;
  fcr_result_t step_result;
  logic        advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  fcr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= step_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_done    = out_result_r.frame_done;
  assign out_frame_status  = out_result_r.frame_status;
  assign out_command_seen  = out_result_r.command_seen;
  assign out_relay_request = out_result_r.relay_request;

endmodule

FILE: rtl/fcr_parser.sv
module fcr_parser
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  rx_byte,
  output fcr_result_t result
);

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [IDX_W-1:0] payload_length_r, payload_length_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic             checksum_matched_r, checksum_matched_nxt;
  logic             relay_flag_r, relay_flag_nxt;
  logic [7:0]       leading_payload_r [LEAD_DEPTH];

  logic [IDX_W:0]      sum_end;
  logic [IDX_W-1:0]    pos;
  logic                lead_we;
  logic [LEAD_IDX_W-1:0] lead_pos;
  logic                open_match;
  logic                close_match;

  assign sum_end = {1'b0, payload_length_r} + (IDX_W + 1)'(2);
  assign pos     = byte_index_r - IDX_W'(2);

  always_comb begin
    open_match = (payload_length_r >= IDX_W'(4));
    for (int i = 0; i < 4; i++) begin
      if (leading_payload_r[i] != WORD_OPEN[i]) begin
        open_match = 1'b0;
      end
    end
    close_match = (payload_length_r >= IDX_W'(5));
    for (int i = 0; i < 5; i++) begin
      if (leading_payload_r[i] != WORD_CLOSE[i]) begin
        close_match = 1'b0;
      end
    end
  end

  always_comb begin
    byte_index_nxt       = byte_index_r;
    payload_length_nxt   = payload_length_r;
    running_xor_nxt      = running_xor_r;
    checksum_matched_nxt = checksum_matched_r;
    relay_flag_nxt       = relay_flag_r;
    lead_we              = 1'b0;
    lead_pos             = pos[LEAD_IDX_W-1:0];
    result.frame_done    = 1'b0;
    result.frame_status  = STATUS_OK;
    result.command_seen  = CMD_NONE;

    if (byte_index_r == '0) begin
      if (rx_byte == HEAD_BYTE) begin
        running_xor_nxt      = HEAD_BYTE;
        checksum_matched_nxt = 1'b0;
        byte_index_nxt       = IDX_W'(1);
      end
    end else if (byte_index_r == IDX_W'(1)) begin
      if (rx_byte > 8'(MAX_PAYLOAD)) begin
        result.frame_done   = 1'b1;
        result.frame_status = STATUS_TOO_LONG;
        byte_index_nxt      = '0;
      end else begin
        payload_length_nxt = rx_byte[IDX_W-1:0];
        running_xor_nxt    = running_xor_r ^ rx_byte;
        byte_index_nxt     = IDX_W'(2);
      end
    end else if ({1'b0, byte_index_r} < sum_end) begin
      lead_we         = (pos < IDX_W'(LEAD_DEPTH));
      running_xor_nxt = running_xor_r ^ rx_byte;
      byte_index_nxt  = byte_index_r + IDX_W'(1);
    end else if ({1'b0, byte_index_r} == sum_end) begin
      checksum_matched_nxt = (rx_byte == running_xor_r);
      byte_index_nxt       = byte_index_r + IDX_W'(1);
    end else begin
      result.frame_done = 1'b1;
      byte_index_nxt    = '0;
      if (rx_byte != TAIL_BYTE) begin
        result.frame_status = STATUS_BAD_TAIL;
      end else if (!checksum_matched_r) begin
        result.frame_status = STATUS_BAD_SUM;
      end else if (open_match) begin
        result.command_seen = CMD_OPEN;
        relay_flag_nxt      = 1'b1;
      end else if (close_match) begin
        result.command_seen = CMD_CLOSE;
        relay_flag_nxt      = 1'b0;
      end
    end

    result.relay_request = relay_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r       <= '0;
      payload_length_r   <= '0;
      running_xor_r      <= '0;
      checksum_matched_r <= 1'b0;
      relay_flag_r       <= 1'b0;
    end else if (step_en) begin
      byte_index_r       <= byte_index_nxt;
      payload_length_r   <= payload_length_nxt;
      running_xor_r      <= running_xor_nxt;
      checksum_matched_r <= checksum_matched_nxt;
      relay_flag_r       <= relay_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && lead_we) begin
      leading_payload_r[lead_pos] <= rx_byte;
    end
  end

endmodule

FILE: rtl/fcr_checker.sv
module fcr_checker
  import fcr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_frame_done,
  input logic [1:0] out_frame_status,
  input logic [1:0] out_command_seen,
  input logic       out_relay_request
);

  // A stalled result transaction must hold its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_done)
      && $stable(out_frame_status) && $stable(out_command_seen)
      && $stable(out_relay_request))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != STATUS_OK |-> out_frame_done)
    else $error("error status without the end of a frame");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_seen != CMD_NONE
      |-> out_frame_done && out_frame_status == STATUS_OK)
    else $error("command reported for a frame that did not end well");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_seen == CMD_OPEN |-> out_relay_request)
    else $error("open command left the relay off");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_seen == CMD_CLOSE |-> !out_relay_request)
    else $error("close command left the relay on");

endmodule

bind framed_command_receiver_top fcr_checker u_fcr_checker (.*);

FILE: test/tb_framed_command_receiver_top.sv
`timescale 1ns / 100ps

module tb_framed_command_receiver_top;
  import fcr_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 450;

  class frame_checker;
    fcr_result_t awaited_results[$];
    int unsigned mismatches;
    logic [6:0]  frame_pos;
    logic [6:0]  frame_len;
    logic [7:0]  xor_acc;
    logic        sum_ok;
    logic [7:0]  lead_bytes[LEAD_DEPTH];
    logic        relay;

    function new();
      mismatches = 0;
      frame_pos  = '0;
      frame_len  = '0;
      xor_acc    = '0;
      sum_ok     = 1'b0;
      relay      = 1'b0;
      foreach (lead_bytes[i]) lead_bytes[i] = '0;
    endfunction

    // Works out the result that one accepted byte must produce.
    function void take_byte(logic [7:0] b);
      fcr_result_t r;
      int pos_i;
      int len_i;
      bit open_hit;
      bit close_hit;
      pos_i = frame_pos;
      len_i = frame_len;
      r.frame_done   = 1'b0;
      r.frame_status = STATUS_OK;
      r.command_seen = CMD_NONE;
      if (pos_i == 0) begin
        if (b == HEAD_BYTE) begin
          xor_acc   = HEAD_BYTE;
          sum_ok    = 1'b0;
          frame_pos = 7'd1;
        end
      end else if (pos_i == 1) begin
        if (b > MAX_PAYLOAD) begin
          r.frame_done   = 1'b1;
          r.frame_status = STATUS_TOO_LONG;
          frame_pos      = '0;
        end else begin
          frame_len = b[6:0];
          xor_acc   = xor_acc ^ b;
          frame_pos = 7'd2;
        end
      end else if (pos_i < len_i + 2) begin
        if (pos_i - 2 < int'(LEAD_DEPTH)) lead_bytes[pos_i - 2] = b;
        xor_acc   = xor_acc ^ b;
        frame_pos = frame_pos + 7'd1;
      end else if (pos_i == len_i + 2) begin
        sum_ok    = (b == xor_acc);
        frame_pos = frame_pos + 7'd1;
      end else begin
        r.frame_done = 1'b1;
        frame_pos    = '0;
        open_hit     = (len_i >= 4);
        close_hit    = (len_i >= 5);
        for (int i = 0; i < 4; i++) begin
          if (lead_bytes[i] != WORD_OPEN[i]) open_hit = 1'b0;
        end
        for (int i = 0; i < 5; i++) begin
          if (lead_bytes[i] != WORD_CLOSE[i]) close_hit = 1'b0;
        end
        if (b != TAIL_BYTE) begin
          r.frame_status = STATUS_BAD_TAIL;
        end else if (!sum_ok) begin
          r.frame_status = STATUS_BAD_SUM;
        end else if (open_hit) begin
          r.command_seen = CMD_OPEN;
          relay          = 1'b1;
        end else if (close_hit) begin
          r.command_seen = CMD_CLOSE;
          relay          = 1'b0;
        end
      end
      r.relay_request = relay;
      awaited_results.push_back(r);
    endfunction

    function void check_result(fcr_result_t got);
      fcr_result_t want;
      if (awaited_results.size() == 0) begin
        $error("Result transaction arrived with none expected.");
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
        mismatches++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, actual %0d", want.frame_status, got.frame_status);
        mismatches++;
      end
      if (got.command_seen !== want.command_seen) begin
        $error("command_seen: expected %0d, actual %0d", want.command_seen, got.command_seen);
        mismatches++;
      end
      if (got.relay_request !== want.relay_request) begin
        $error("relay_request: expected %0d, actual %0d", want.relay_request,
               got.relay_request);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_frame_done;
  logic [1:0] out_frame_status;
  logic [1:0] out_command_seen;
  logic       out_relay_request;

  frame_checker checker_h;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int frame_bytes   = 0;
  int quiet_cycles  = 0;

  framed_command_receiver_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_done    (out_frame_done),
    .out_frame_status  (out_frame_status),
    .out_command_seen  (out_command_seen),
    .out_relay_request (out_relay_request)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    fcr_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) checker_h.take_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got.frame_done    = out_frame_done;
        got.frame_status  = fcr_status_t'(out_frame_status);
        got.command_seen  = fcr_cmd_t'(out_command_seen);
        got.relay_request = out_relay_request;
        checker_h.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] body[$], input logic [7:0] sum_flip,
                            input logic [7:0] tail);
    logic [7:0] sum;
    sum = HEAD_BYTE ^ 8'(body.size());
    foreach (body[i]) sum = sum ^ body[i];
    send_byte(HEAD_BYTE);
    send_byte(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(sum ^ sum_flip);
    send_byte(tail);
    frame_bytes += body.size() + 4;
  endtask

  // Mostly well-formed frames with random content, plus line noise, oversized
  // lengths, corrupted checksums and damaged tails.
  task automatic send_random_unit();
    logic [7:0] body[$];
    logic [7:0] noise;
    logic [7:0] flip;
    logic [7:0] tail;
    int kind;
    int len;
    int pick;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) begin
        do noise = 8'($urandom_range(255)); while (noise == HEAD_BYTE);
        send_byte(noise);
      end
    end else if (kind < 16) begin
      send_byte(HEAD_BYTE);
      send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      frame_bytes += 2;
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) len = MAX_PAYLOAD;
      else if (pick < 10) len = $urandom_range(9, MAX_PAYLOAD - 1);
      else len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 35) begin
        for (int i = 0; i < 4 && i < len; i++) body[i] = WORD_OPEN[i];
      end else if (pick < 65) begin
        for (int i = 0; i < 5 && i < len; i++) body[i] = WORD_CLOSE[i];
      end else if (pick < 72 && len > 1) begin
        for (int i = 0; i < 3 && i < len; i++) body[i] = WORD_CLOSE[i];
      end
      flip = ($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
      tail = ($urandom_range(99) < 12) ? 8'($urandom_range(255)) : TAIL_BYTE;
      send_frame(body, flip, tail);
    end
  endtask

  initial begin
    logic [7:0] body[$];
    checker_h     = new();
    send_idle_pct = 20;
    recv_idle_pct = 51;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(HEAD_BYTE);
    send_byte(8'(MAX_PAYLOAD + 1));
    frame_bytes += 2;
    send_frame(body, 8'h00, TAIL_BYTE);
    for (int i = 0; i < 4; i++) body.push_back(WORD_OPEN[i]);
    send_frame(body, 8'h00, TAIL_BYTE);
    body.delete();
    for (int i = 0; i < 5; i++) body.push_back(WORD_CLOSE[i]);
    send_frame(body, 8'h80, TAIL_BYTE);
    body.delete();
    body.push_back(HEAD_BYTE);
    send_frame(body, 8'h00, 8'hFF);

    while (frame_bytes < PHASE_ITEMS) send_random_unit();
    send_idle_pct = 51;
    recv_idle_pct = 20;
    while (frame_bytes < 2 * PHASE_ITEMS) send_random_unit();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (frame_bytes < 3 * PHASE_ITEMS) send_random_unit();
    in_valid <= 1'b0;

    while (checker_h.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (checker_h.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
